/* design/nbg_pkg.sv */
// Shared types, register map and micro-op tables for the 2-D gravity stepper.
`default_nettype none

package nbg_pkg;

	// Datapath operations issued by the sequencer.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_RDA,
		OP_RDB,
		OP_OFF,
		OP_MUL,
		OP_SQRT,
		OP_DIV,
		OP_UPD,
		OP_WRA,
		OP_WRB
	} op_t;

	// Operand and destination selection of the shared serial multiplier.
	typedef enum logic [3:0] {
		M_AXAX,
		M_AYAY,
		M_D2SQ,
		M_GMA,
		M_GMB,
		M_GMDT,
		M_NUMX,
		M_NUMY,
		M_ADVX,
		M_ADVY
	} mul_sel_t;

	// Operand selection of the shared serial divider.
	typedef enum logic {
		D_DT,
		D_PULL
	} div_sel_t;

	// Saturating accumulate targets.
	typedef enum logic [2:0] {
		U_VAX,
		U_VAY,
		U_VBX,
		U_VBY,
		U_PX,
		U_PY
	} upd_sel_t;

	typedef struct packed {
		op_t      op;
		mul_sel_t msel;
		div_sel_t dsel;
		upd_sel_t usel;
	} uop_t;

	typedef struct packed {
		logic done;
		logic zero;
	} dp_stat_t;

	// Register map, word index.
	localparam logic [1:0] REG_GRAVITY = 2'd0;
	localparam logic [1:0] REG_FRAME   = 2'd1;
	localparam logic [1:0] REG_SUBSTEP = 2'd2;

	localparam logic [31:0] GRAVITY_RST = 32'd53084;
	localparam logic [16:0] FRAME_RST   = 17'd1092;
	localparam logic [4:0]  SUBSTEP_RST = 5'd5;
	localparam logic [4:0]  SUBSTEP_MAX = 5'd16;

	// Sequence positions that the controller tests.
	localparam logic [4:0] PAIR_OFF_STEP = 5'd2;
	localparam logic [4:0] PAIR_LAST     = 5'd24;
	localparam logic [4:0] ADV_LAST      = 5'd5;

	function automatic uop_t mk(op_t o, mul_sel_t m, div_sel_t d, upd_sel_t u);
		uop_t r;
		r.op   = o;
		r.msel = m;
		r.dsel = d;
		r.usel = u;
		return r;
	endfunction

	// One pair interaction: fetch, offset, distance, then the four pulls and the write-back of both bodies.
	function automatic uop_t pair_uop(logic [4:0] s);
		uop_t r;
		case (s)
			5'd0:    r = mk(OP_RDA,  M_AXAX, D_PULL, U_VAX);
			5'd1:    r = mk(OP_RDB,  M_AXAX, D_PULL, U_VAX);
			5'd2:    r = mk(OP_OFF,  M_AXAX, D_PULL, U_VAX);
			5'd3:    r = mk(OP_MUL,  M_AXAX, D_PULL, U_VAX);
			5'd4:    r = mk(OP_MUL,  M_AYAY, D_PULL, U_VAX);
			5'd5:    r = mk(OP_SQRT, M_AXAX, D_PULL, U_VAX);
			5'd6:    r = mk(OP_MUL,  M_D2SQ, D_PULL, U_VAX);
			5'd7:    r = mk(OP_MUL,  M_GMB,  D_PULL, U_VAX);
			5'd8:    r = mk(OP_MUL,  M_GMDT, D_PULL, U_VAX);
			5'd9:    r = mk(OP_MUL,  M_NUMX, D_PULL, U_VAX);
			5'd10:   r = mk(OP_DIV,  M_AXAX, D_PULL, U_VAX);
			5'd11:   r = mk(OP_UPD,  M_AXAX, D_PULL, U_VAX);
			5'd12:   r = mk(OP_MUL,  M_NUMY, D_PULL, U_VAX);
			5'd13:   r = mk(OP_DIV,  M_AXAX, D_PULL, U_VAX);
			5'd14:   r = mk(OP_UPD,  M_AXAX, D_PULL, U_VAY);
			5'd15:   r = mk(OP_MUL,  M_GMA,  D_PULL, U_VAX);
			5'd16:   r = mk(OP_MUL,  M_GMDT, D_PULL, U_VAX);
			5'd17:   r = mk(OP_MUL,  M_NUMX, D_PULL, U_VAX);
			5'd18:   r = mk(OP_DIV,  M_AXAX, D_PULL, U_VAX);
			5'd19:   r = mk(OP_UPD,  M_AXAX, D_PULL, U_VBX);
			5'd20:   r = mk(OP_MUL,  M_NUMY, D_PULL, U_VAX);
			5'd21:   r = mk(OP_DIV,  M_AXAX, D_PULL, U_VAX);
			5'd22:   r = mk(OP_UPD,  M_AXAX, D_PULL, U_VBY);
			5'd23:   r = mk(OP_WRA,  M_AXAX, D_PULL, U_VAX);
			5'd24:   r = mk(OP_WRB,  M_AXAX, D_PULL, U_VAX);
			default: r = mk(OP_NOP,  M_AXAX, D_PULL, U_VAX);
		endcase
		return r;
	endfunction

	// Position advance of one body.
	function automatic uop_t adv_uop(logic [4:0] s);
		uop_t r;
		case (s)
			5'd0:    r = mk(OP_RDA, M_AXAX, D_PULL, U_PX);
			5'd1:    r = mk(OP_MUL, M_ADVX, D_PULL, U_PX);
			5'd2:    r = mk(OP_UPD, M_AXAX, D_PULL, U_PX);
			5'd3:    r = mk(OP_MUL, M_ADVY, D_PULL, U_PY);
			5'd4:    r = mk(OP_UPD, M_AXAX, D_PULL, U_PY);
			5'd5:    r = mk(OP_WRA, M_AXAX, D_PULL, U_PX);
			default: r = mk(OP_NOP, M_AXAX, D_PULL, U_PX);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/nbody_gravity_step_2d.sv */
// Top level of the 2-D direct-sum gravity stepper: register port, controller and datapath.
//
// Bodies arrive one word per accepted input (in_valid and in_ready high at a clock edge):
// position, velocity and mass. The word with last_body set closes the set and starts a
// frame; a word that arrives with the store already full is dropped, but its last_body
// flag still starts the frame. The frame is split into substep_count equal substeps
// (clamped to 1..16), each applying the pull of every pair at distinct positions and
// then advancing every position. Updated bodies then leave on the output channel in
// load order, one word each, last_result on the final one. in_ready is low from the
// start of a frame until its final word is taken. Bodies may arrive back to back while
// in_ready is high. A frame first divides frame_time by the substep count for the
// substep time, then runs the substeps on the shared bit-serial multiplier (one
// multiplier bit per cycle), the restoring divider and the square root, which every
// pair uses in turn. Each output word is read back from the store before it is offered;
// a stalled word holds steady and the block simply waits.
// Reset clears the body count, the clamp flags and the sequencer, and restores the
// register defaults; the body store itself keeps whatever it held.
// Registers: gravity_strength at 0x0, frame_time at 0x4, substep_count at 0x8.
`default_nettype none

module nbody_gravity_step_2d #(
	parameter int MAX_BODIES = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] position_x,
	input  wire logic signed [31:0] position_y,
	input  wire logic signed [31:0] velocity_x,
	input  wire logic signed [31:0] velocity_y,
	input  wire logic [31:0]        body_mass,
	input  wire logic               last_body,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [5:0]              body_index,
	output logic signed [31:0]      new_position_x,
	output logic signed [31:0]      new_position_y,
	output logic signed [31:0]      new_velocity_x,
	output logic signed [31:0]      new_velocity_y,
	output logic                    saturated,
	output logic                    last_result
);
	import nbg_pkg::*;

	localparam int AW = $clog2(MAX_BODIES);
	localparam int CW = $clog2(MAX_BODIES + 1);

	logic [31:0]   gravity_q;
	logic [16:0]   frame_q;
	logic [4:0]    substep_q;
	logic [4:0]    steps;
	logic          wr_fire;
	uop_t          cmd;
	dp_stat_t      stat;
	logic [AW-1:0] addr_a, addr_b;

	// Register writes.
	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RST;
			frame_q   <= FRAME_RST;
			substep_q <= SUBSTEP_RST;
		end else if (wr_fire) begin
			case (paddr[3:2])
				REG_GRAVITY: gravity_q <= pwdata;
				REG_FRAME:   frame_q   <= pwdata[16:0];
				REG_SUBSTEP: substep_q <= pwdata[4:0];
				default:     gravity_q <= gravity_q;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (paddr[3:2])
			REG_GRAVITY: prdata = gravity_q;
			REG_FRAME:   prdata = 32'(frame_q);
			REG_SUBSTEP: prdata = 32'(substep_q);
			default:     prdata = '0;
		endcase
	end

	// Zero substeps act as one, more than the maximum as the maximum.
	assign steps = (substep_q == 5'd0) ? 5'd1 :
		((substep_q > SUBSTEP_MAX) ? SUBSTEP_MAX : substep_q);

	nbg_ctrl #(
		.MAX_BODIES(MAX_BODIES),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.last_body(last_body),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.last_result(last_result),
		.body_index(body_index),
		.steps(steps),
		.stat(stat),
		.cmd(cmd),
		.addr_a(addr_a),
		.addr_b(addr_b)
	);

	nbg_dp #(
		.MAX_BODIES(MAX_BODIES),
		.FRAC_BITS(FRAC_BITS),
		.AW(AW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.addr_a(addr_a),
		.addr_b(addr_b),
		.position_x(position_x),
		.position_y(position_y),
		.velocity_x(velocity_x),
		.velocity_y(velocity_y),
		.body_mass(body_mass),
		.gravity(gravity_q),
		.frame_len(frame_q),
		.steps(steps),
		.stat(stat),
		.new_position_x(new_position_x),
		.new_position_y(new_position_y),
		.new_velocity_x(new_velocity_x),
		.new_velocity_y(new_velocity_y),
		.saturated(saturated)
	);

endmodule

`default_nettype wire

/* design/nbg_dp.sv */
// Datapath: body store, working registers, serial multiplier, divider and square root.
`default_nettype none

module nbg_dp #(
	parameter int MAX_BODIES = 16,
	parameter int FRAC_BITS  = 16,
	parameter int AW         = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire nbg_pkg::uop_t       cmd,
	input  wire logic [AW-1:0]       addr_a,
	input  wire logic [AW-1:0]       addr_b,
	input  wire logic signed [31:0]  position_x,
	input  wire logic signed [31:0]  position_y,
	input  wire logic signed [31:0]  velocity_x,
	input  wire logic signed [31:0]  velocity_y,
	input  wire logic [31:0]         body_mass,
	input  wire logic [31:0]         gravity,
	input  wire logic [16:0]         frame_len,
	input  wire logic [4:0]          steps,
	output nbg_pkg::dp_stat_t        stat,
	output logic signed [31:0]       new_position_x,
	output logic signed [31:0]       new_position_y,
	output logic signed [31:0]       new_velocity_x,
	output logic signed [31:0]       new_velocity_y,
	output logic                     saturated
);
	import nbg_pkg::*;

	// Body store.
	logic signed [31:0] px_mem [MAX_BODIES];
	logic signed [31:0] py_mem [MAX_BODIES];
	logic signed [31:0] vx_mem [MAX_BODIES];
	logic signed [31:0] vy_mem [MAX_BODIES];
	logic [31:0]        m_mem  [MAX_BODIES];
	logic [MAX_BODIES-1:0] sat_q;

	// Working registers for bodies a and b.
	logic signed [31:0] xa_q, ya_q, vxa_q, vya_q, xb_q, yb_q, vxb_q, vyb_q;
	logic [31:0]        ma_q, mb_q;
	logic [32:0]        ax_q, ay_q;
	logic               sx_q, sy_q, zero_q;
	logic [16:0]        dt_q;
	logic [65:0]        d2_q;
	logic [33:0]        sq_q;
	logic [127:0]       den_q, gmdt_q, num_q;
	logic [63:0]        gm_q;
	logic [48:0]        advm_q;
	logic [32:0]        pq_q;
	logic               done_q;

	// Serial multiplier state.
	logic [127:0] mc_q, acc_q;
	logic [63:0]  mp_q;
	logic         mbusy_q;
	mul_sel_t     msel_q;
	logic [127:0] mul_a;
	logic [63:0]  mul_b;
	logic         mul_fin;

	// Serial divider state.
	logic [127:0] dn_q, dd_q;
	logic [128:0] dr_q;
	logic [32:0]  dq_q;
	logic         dovf_q, dbusy_q;
	logic [6:0]   dcnt_q;
	div_sel_t     dsel_q;
	logic [128:0] dr_shift, dr_next;
	logic         dbit, div_fin;
	logic [32:0]  dq_next, dq_cap;
	logic         dovf_next;

	// Square root state.
	logic [67:0] sr_q;
	logic [37:0] srem_q;
	logic [33:0] sroot_q;
	logic [5:0]  scnt_q;
	logic        sbusy_q;
	logic [37:0] srem_shift, strial, srem_next;
	logic [33:0] sroot_next;
	logic        sqrt_fin;

	// Offsets and update terms.
	logic signed [32:0] dx, dy;
	logic [31:0]        avxa, avya;
	logic signed [49:0] upd_v, upd_delta, upd_sum, q_ext, adv_ext;
	logic [48:0]        adv_mag;
	logic signed [31:0] upd_res;
	logic               upd_ovf;
	logic [AW-1:0]      upd_idx;

	// Store write port.
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_px, wr_py, wr_vx, wr_vy;
	logic [31:0]        wr_m;
	logic [AW-1:0]      rd_addr;

	// Offsets and magnitudes.
	assign dx   = 33'(xa_q) - 33'(xb_q);
	assign dy   = 33'(ya_q) - 33'(yb_q);
	assign avxa = vxa_q[31] ? 32'(-vxa_q) : 32'(vxa_q);
	assign avya = vya_q[31] ? 32'(-vya_q) : 32'(vya_q);

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.msel)
			M_AXAX: begin mul_a = 128'(ax_q);   mul_b = 64'(ax_q); end
			M_AYAY: begin mul_a = 128'(ay_q);   mul_b = 64'(ay_q); end
			M_D2SQ: begin mul_a = 128'(d2_q);   mul_b = 64'(sq_q); end
			M_GMA:  begin mul_a = 128'(gravity); mul_b = 64'(ma_q); end
			M_GMB:  begin mul_a = 128'(gravity); mul_b = 64'(mb_q); end
			M_GMDT: begin mul_a = 128'(gm_q);   mul_b = 64'(dt_q); end
			M_NUMX: begin mul_a = gmdt_q;       mul_b = 64'(ax_q); end
			M_NUMY: begin mul_a = gmdt_q;       mul_b = 64'(ay_q); end
			M_ADVX: begin mul_a = 128'(avxa);   mul_b = 64'(dt_q); end
			M_ADVY: begin mul_a = 128'(avya);   mul_b = 64'(dt_q); end
			default: begin mul_a = '0;          mul_b = '0; end
		endcase
	end

	assign mul_fin = mbusy_q && (mp_q == '0);

	// One restoring-division bit per cycle.
	always_comb begin
		dr_shift  = {dr_q[127:0], dn_q[127]};
		dbit      = dr_shift >= {1'b0, dd_q};
		dr_next   = dbit ? dr_shift - {1'b0, dd_q} : dr_shift;
		dq_next   = {dq_q[31:0], dbit};
		dovf_next = dovf_q | dq_q[32];
		dq_cap    = (dovf_next || dq_next > 33'h1_0000_0000) ? 33'h1_0000_0000 : dq_next;
	end
	assign div_fin = dbusy_q && (dcnt_q == 7'd127);

	// One square-root digit per cycle.
	always_comb begin
		srem_shift = {srem_q[35:0], sr_q[67:66]};
		strial     = {2'b00, sroot_q, 2'b01};
		if (srem_shift >= strial) begin
			srem_next  = srem_shift - strial;
			sroot_next = {sroot_q[32:0], 1'b1};
		end else begin
			srem_next  = srem_shift;
			sroot_next = {sroot_q[32:0], 1'b0};
		end
	end
	assign sqrt_fin = sbusy_q && (scnt_q == 6'd33);

	// Saturating update of one velocity or position component.
	always_comb begin
		q_ext   = 50'(pq_q);
		adv_mag = advm_q >> FRAC_BITS;
		adv_ext = 50'(adv_mag);
		upd_v     = 50'(vxa_q);
		upd_delta = '0;
		upd_idx   = addr_a;
		case (cmd.usel)
			U_VAX: begin upd_v = 50'(vxa_q); upd_delta = sx_q ? q_ext : -q_ext; end
			U_VAY: begin upd_v = 50'(vya_q); upd_delta = sy_q ? q_ext : -q_ext; end
			U_VBX: begin
				upd_v = 50'(vxb_q); upd_delta = sx_q ? -q_ext : q_ext; upd_idx = addr_b;
			end
			U_VBY: begin
				upd_v = 50'(vyb_q); upd_delta = sy_q ? -q_ext : q_ext; upd_idx = addr_b;
			end
			U_PX:  begin upd_v = 50'(xa_q); upd_delta = vxa_q[31] ? -adv_ext : adv_ext; end
			U_PY:  begin upd_v = 50'(ya_q); upd_delta = vya_q[31] ? -adv_ext : adv_ext; end
			default: begin upd_v = 50'(vxa_q); upd_delta = '0; end
		endcase
		upd_sum = upd_v + upd_delta;
		if (upd_sum > 50'sd2147483647) begin
			upd_res = 32'sh7FFF_FFFF;
			upd_ovf = 1'b1;
		end else if (upd_sum < -50'sd2147483648) begin
			upd_res = 32'sh8000_0000;
			upd_ovf = 1'b1;
		end else begin
			upd_res = upd_sum[31:0];
			upd_ovf = 1'b0;
		end
	end

	// Store write port: load, write back of body a or of body b.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_a;
		wr_px   = xa_q;
		wr_py   = ya_q;
		wr_vx   = vxa_q;
		wr_vy   = vya_q;
		wr_m    = ma_q;
		case (cmd.op)
			OP_LOAD: begin
				wr_en = 1'b1;
				wr_px = position_x;
				wr_py = position_y;
				wr_vx = velocity_x;
				wr_vy = velocity_y;
				wr_m  = body_mass;
			end
			OP_WRA: wr_en = 1'b1;
			OP_WRB: begin
				wr_en   = 1'b1;
				wr_addr = addr_b;
				wr_px   = xb_q;
				wr_py   = yb_q;
				wr_vx   = vxb_q;
				wr_vy   = vyb_q;
				wr_m    = mb_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign rd_addr = (cmd.op == OP_RDB) ? addr_b : addr_a;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			px_mem[wr_addr] <= wr_px;
			py_mem[wr_addr] <= wr_py;
			vx_mem[wr_addr] <= wr_vx;
			vy_mem[wr_addr] <= wr_vy;
			m_mem[wr_addr]  <= wr_m;
		end
	end

	// Clamp flags: cleared at load, set by any clamped update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= '0;
		end else if (cmd.op == OP_LOAD) begin
			sat_q[addr_a] <= 1'b0;
		end else if (cmd.op == OP_UPD && upd_ovf) begin
			sat_q[upd_idx] <= 1'b1;
		end
	end

	// Unit control and completion. Non-serial operations other than NOP finish at once, the
	// serial units when their last iteration is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
			sbusy_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= mul_fin || div_fin || sqrt_fin ||
				!(cmd.op inside {OP_NOP, OP_MUL, OP_DIV, OP_SQRT});
			if (cmd.op == OP_MUL) mbusy_q <= 1'b1;
			else if (mul_fin) mbusy_q <= 1'b0;
			if (cmd.op == OP_DIV) dbusy_q <= 1'b1;
			else if (div_fin) dbusy_q <= 1'b0;
			if (cmd.op == OP_SQRT) sbusy_q <= 1'b1;
			else if (sqrt_fin) sbusy_q <= 1'b0;
		end
	end

	// Working registers and iteration registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_RDA: begin
				xa_q  <= px_mem[rd_addr];
				ya_q  <= py_mem[rd_addr];
				vxa_q <= vx_mem[rd_addr];
				vya_q <= vy_mem[rd_addr];
				ma_q  <= m_mem[rd_addr];
			end
			OP_RDB: begin
				xb_q  <= px_mem[rd_addr];
				yb_q  <= py_mem[rd_addr];
				vxb_q <= vx_mem[rd_addr];
				vyb_q <= vy_mem[rd_addr];
				mb_q  <= m_mem[rd_addr];
			end
			OP_OFF: begin
				ax_q   <= dx[32] ? 33'(-dx) : 33'(dx);
				ay_q   <= dy[32] ? 33'(-dy) : 33'(dy);
				sx_q   <= dx[32];
				sy_q   <= dy[32];
				zero_q <= (dx == '0) && (dy == '0);
			end
			OP_MUL: begin
				mc_q   <= mul_a;
				mp_q   <= mul_b;
				acc_q  <= '0;
				msel_q <= cmd.msel;
			end
			OP_DIV: begin
				dsel_q <= cmd.dsel;
				dr_q   <= '0;
				dq_q   <= '0;
				dovf_q <= 1'b0;
				dcnt_q <= '0;
				if (cmd.dsel == D_DT) begin
					dn_q <= 128'(frame_len);
					dd_q <= 128'(steps);
				end else begin
					dn_q <= num_q;
					dd_q <= den_q;
				end
			end
			OP_SQRT: begin
				sr_q    <= {2'b00, d2_q};
				srem_q  <= '0;
				sroot_q <= '0;
				scnt_q  <= '0;
			end
			OP_UPD: begin
				case (cmd.usel)
					U_VAX:   vxa_q <= upd_res;
					U_VAY:   vya_q <= upd_res;
					U_VBX:   vxb_q <= upd_res;
					U_VBY:   vyb_q <= upd_res;
					U_PX:    xa_q  <= upd_res;
					U_PY:    ya_q  <= upd_res;
					default: xa_q  <= xa_q;
				endcase
			end
			default: begin
			end
		endcase

		// Shift-add multiplier, one multiplier bit per cycle.
		if (mbusy_q && !mul_fin) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[126:0], 1'b0};
			mp_q <= {1'b0, mp_q[63:1]};
		end
		if (mul_fin) begin
			case (msel_q)
				M_AXAX:  d2_q   <= acc_q[65:0];
				M_AYAY:  d2_q   <= d2_q + acc_q[65:0];
				M_D2SQ:  den_q  <= acc_q;
				M_GMA:   gm_q   <= acc_q[63:0];
				M_GMB:   gm_q   <= acc_q[63:0];
				M_GMDT:  gmdt_q <= acc_q;
				M_NUMX:  num_q  <= acc_q;
				M_NUMY:  num_q  <= acc_q;
				M_ADVX:  advm_q <= acc_q[48:0];
				M_ADVY:  advm_q <= acc_q[48:0];
				default: advm_q <= acc_q[48:0];
			endcase
		end

		// Restoring divider.
		if (dbusy_q) begin
			dr_q   <= dr_next;
			dq_q   <= dq_next;
			dovf_q <= dovf_next;
			dn_q   <= {dn_q[126:0], 1'b0};
			dcnt_q <= dcnt_q + 7'd1;
		end
		if (div_fin) begin
			if (dsel_q == D_DT) dt_q <= dq_next[16:0];
			else pq_q <= dq_cap;
		end

		// Digit-by-digit square root.
		if (sbusy_q) begin
			srem_q  <= srem_next;
			sroot_q <= sroot_next;
			sr_q    <= {sr_q[65:0], 2'b00};
			scnt_q  <= scnt_q + 6'd1;
		end
		if (sqrt_fin) sq_q <= sroot_next;
	end

	assign stat.done = done_q;
	assign stat.zero = zero_q;

	assign new_position_x = xa_q;
	assign new_position_y = ya_q;
	assign new_velocity_x = vxa_q;
	assign new_velocity_y = vya_q;
	assign saturated      = sat_q[addr_a];

endmodule

`default_nettype wire

/* design/nbg_ctrl.sv */
// Controller: load counting, substep and pair loops, micro-op sequencing and result handshake.
`default_nettype none

module nbg_ctrl #(
	parameter int MAX_BODIES = 16,
	parameter int AW         = 4,
	parameter int CW         = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              last_body,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   last_result,
	output logic [5:0]             body_index,
	input  wire logic [4:0]        steps,
	input  wire nbg_pkg::dp_stat_t stat,
	output nbg_pkg::uop_t          cmd,
	output logic [AW-1:0]          addr_a,
	output logic [AW-1:0]          addr_b
);
	import nbg_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_DT_GO = 10'b00_0000_0010,
		S_DT_WT = 10'b00_0000_0100,
		S_PR_GO = 10'b00_0000_1000,
		S_PR_WT = 10'b00_0001_0000,
		S_AD_GO = 10'b00_0010_0000,
		S_AD_WT = 10'b00_0100_0000,
		S_EM_GO = 10'b00_1000_0000,
		S_EM_WT = 10'b01_0000_0000,
		S_EMIT  = 10'b10_0000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [4:0]    step_q, step_d, sub_q, sub_d;
	logic [CW-1:0] ia_q, ia_d, ib_q, ib_d, cnt_q, cnt_d;
	logic          accept, has_room;
	logic [CW:0]   ia_inc, ib_inc, ia_two, n_ext;
	uop_t          pair_op, adv_op;

	assign has_room = cnt_q < CW'(MAX_BODIES);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign ia_inc   = {1'b0, ia_q} + 1'b1;
	assign ib_inc   = {1'b0, ib_q} + 1'b1;
	assign ia_two   = {1'b0, ia_q} + 2'd2;
	assign n_ext    = {1'b0, cnt_q};
	assign pair_op  = pair_uop(step_q);
	assign adv_op   = adv_uop(step_q);

	// Micro-op issue.
	always_comb begin
		cmd = mk(OP_NOP, M_AXAX, D_DT, U_VAX);
		case (state_q)
			S_IDLE:  if (accept && has_room) cmd = mk(OP_LOAD, M_AXAX, D_DT, U_VAX);
			S_DT_GO: cmd = mk(OP_DIV, M_AXAX, D_DT, U_VAX);
			S_PR_GO: cmd = pair_op;
			S_AD_GO: cmd = adv_op;
			S_EM_GO: cmd = mk(OP_RDA, M_AXAX, D_DT, U_VAX);
			default: cmd = mk(OP_NOP, M_AXAX, D_DT, U_VAX);
		endcase
	end

	assign addr_a = (state_q == S_IDLE) ? cnt_q[AW-1:0] : ia_q[AW-1:0];
	assign addr_b = ib_q[AW-1:0];

	// Loop control.
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		sub_d   = sub_q;
		ia_d    = ia_q;
		ib_d    = ib_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (has_room) cnt_d = cnt_q + 1'b1;
					if (last_body) state_d = S_DT_GO;
				end
			end
			S_DT_GO: state_d = S_DT_WT;
			S_DT_WT: begin
				if (stat.done) begin
					sub_d  = '0;
					step_d = '0;
					ia_d   = '0;
					ib_d   = CW'(1);
					state_d = (cnt_q > CW'(1)) ? S_PR_GO : S_AD_GO;
				end
			end
			S_PR_GO: state_d = S_PR_WT;
			S_PR_WT: begin
				if (stat.done) begin
					if ((step_q == PAIR_OFF_STEP && stat.zero) || step_q == PAIR_LAST) begin
						// Next unordered pair, or on to the position advance.
						step_d = '0;
						if (ib_inc < n_ext) begin
							ib_d    = ib_inc[CW-1:0];
							state_d = S_PR_GO;
						end else if (ia_two < n_ext) begin
							ia_d    = ia_inc[CW-1:0];
							ib_d    = ia_two[CW-1:0];
							state_d = S_PR_GO;
						end else begin
							ia_d    = '0;
							state_d = S_AD_GO;
						end
					end else begin
						step_d  = step_q + 5'd1;
						state_d = S_PR_GO;
					end
				end
			end
			S_AD_GO: state_d = S_AD_WT;
			S_AD_WT: begin
				if (stat.done) begin
					if (step_q == ADV_LAST) begin
						step_d = '0;
						if (ia_inc < n_ext) begin
							ia_d    = ia_inc[CW-1:0];
							state_d = S_AD_GO;
						end else if (sub_q + 5'd1 < steps) begin
							sub_d   = sub_q + 5'd1;
							ia_d    = '0;
							ib_d    = CW'(1);
							state_d = (cnt_q > CW'(1)) ? S_PR_GO : S_AD_GO;
						end else begin
							ia_d    = '0;
							state_d = S_EM_GO;
						end
					end else begin
						step_d  = step_q + 5'd1;
						state_d = S_AD_GO;
					end
				end
			end
			S_EM_GO: state_d = S_EM_WT;
			S_EM_WT: if (stat.done) state_d = S_EMIT;
			S_EMIT: begin
				if (out_ready) begin
					if (ia_inc < n_ext) begin
						ia_d    = ia_inc[CW-1:0];
						state_d = S_EM_GO;
					end else begin
						cnt_d   = '0;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			sub_q   <= '0;
			ia_q    <= '0;
			ib_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sub_q   <= sub_d;
			ia_q    <= ia_d;
			ib_q    <= ib_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_EMIT);
	assign last_result = (ia_inc == n_ext);
	assign body_index  = 6'(ia_q);

endmodule

`default_nettype wire

/* design/nbg_chk.sv */
// Port-level checker for the gravity stepper and its bind to the top level.
`default_nettype none

module nbg_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               last_result,
	input wire logic signed [31:0] new_position_x
);

	// A stalled output word stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_position_x))
		else $error("output word dropped or changed while stalled");

	// No body is taken while a frame is being delivered.
	a_no_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted during result delivery");

	// After the final word of a frame the block returns to loading.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_result |=> !out_valid && in_ready)
		else $error("frame did not close after its final word");

endmodule

bind nbody_gravity_step_2d nbg_chk u_nbg_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.last_result(last_result),
	.new_position_x(new_position_x)
);

`default_nettype wire
